// ===== design/nlrb_pkg.sv =====
// ----------------------------------------------------------------------------
// nlrb_pkg
// shared types and constants of the nmea line ring buffer
// ----------------------------------------------------------------------------
package nlrb_pkg;

  // request word: one received byte or one read of the oldest line
  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } req_word_t;

  // response word: one sentence chunk or the empty status
  typedef struct packed {
    logic        status;
    logic [31:0] chunk;
    logic [2:0]  byte_count;
    logic        last;
  } rsp_word_t;

  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  localparam logic STATUS_CHUNK = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] DOLLAR_CHAR  = 8'h24;

  localparam int CHUNK_BYTES = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_SCAN,
    ST_GATHER,
    ST_SEND
  } state_t;

endpackage

// ===== design/nlrb_mem.sv =====
// ----------------------------------------------------------------------------
// nlrb_mem
// line store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module nlrb_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end

endmodule

// ===== design/nlrb_out_reg.sv =====
// ----------------------------------------------------------------------------
// nlrb_out_reg
// response holding register, frees itself when the receiver takes the word
// ----------------------------------------------------------------------------
module nlrb_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  nlrb_pkg::rsp_word_t load_word,
  output logic               free,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output nlrb_pkg::rsp_word_t rsp
);

  // empty, or the held word leaves at this edge
  assign free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (free) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      rsp <= load_word;
    end
  end

endmodule

// ===== design/nmea_line_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// nmea_line_ring_buffer
// ring of text lines filled from a uart and drained one sentence per read
// ----------------------------------------------------------------------------
// request channel (req_valid / req_stall / req): a receive word stores rx_byte
//   in the current line; a newline commits the line and moves to the next one,
//   overwriting old lines without a full check. a read word drains the oldest
//   committed line from its last '$' through its newline.
// response channel (rsp_valid / rsp_stall / rsp): chunks of up to four bytes,
//   first byte in bits 7..0, last set on the chunk with the newline. a read of
//   an empty ring gives a single word with status set.
// request side: a receive is taken whenever the block is idle; a newline whose
//   terminator still fits in the line then passes through ST_ZERO, as the
//   terminator write uses the single write port. a read walks its line
//   through the registered read port of the line store: it scans for the
//   newline, then per chunk gathers the bytes and hands the chunk to the
//   output register. req_stall stays high for the whole read.
// stall: a waiting response stays in the output register; a read with its next
//   chunk ready holds in its send step, req_stall high, until the register
//   frees. once its last word is loaded, requests are taken again.
// reset: line indices and write position clear, the line store is not
//   cleared (never-written bytes are not read by a legal sequence).
// ----------------------------------------------------------------------------
module nmea_line_ring_buffer #(
  parameter int LINE_BYTES = 128,
  parameter int LINE_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  nlrb_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output nlrb_pkg::rsp_word_t rsp
);

  localparam int POS_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = POS_W + 1;
  localparam int LINE_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int DEPTH  = LINE_COUNT * LINE_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  // flat store address of a byte in a line
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [LINE_W-1:0] line,
                                                   input logic [POS_W-1:0] pos);
    return ADDR_W'(line) * ADDR_W'(LINE_BYTES) + ADDR_W'(pos);
  endfunction

  // ring step with wrap
  function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] line);
    logic [LINE_W-1:0] res;
    if (line == LINE_W'(LINE_COUNT - 1)) begin
      res = '0;
    end else begin
      res = line + 1'b1;
    end
    return res;
  endfunction

  nlrb_pkg::state_t state, state_next;

  // ring pointers
  logic [LINE_W-1:0] wr_line, wr_line_next;
  logic [LINE_W-1:0] rd_line, rd_line_next;
  logic [POS_W-1:0]  wr_pos, wr_pos_next;
  logic [ADDR_W-1:0] zero_addr, zero_addr_next;

  // read walk
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic              dat_vld, dat_vld_next;
  logic [POS_W-1:0]  dat_idx, dat_idx_next;
  logic [1:0]        dat_lane, dat_lane_next;
  logic [2:0]        iss_lane, iss_lane_next;
  logic [POS_W-1:0]  start_pos, start_pos_next;
  logic [POS_W-1:0]  end_pos, end_pos_next;

  // chunk under assembly
  nlrb_pkg::rsp_word_t acc, acc_next;

  // memory and output register hookup
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  logic              out_load;
  logic              out_free;

  logic              req_take;
  logic [IDX_W-1:0]  pos_inc;

  assign req_stall = (state != nlrb_pkg::ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign pos_inc   = {1'b0, wr_pos} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= nlrb_pkg::ST_IDLE;
      wr_line <= '0;
      rd_line <= '0;
      wr_pos  <= '0;
      dat_vld <= 1'b0;
    end else begin
      state   <= state_next;
      wr_line <= wr_line_next;
      rd_line <= rd_line_next;
      wr_pos  <= wr_pos_next;
      dat_vld <= dat_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    zero_addr <= zero_addr_next;
    scan_idx  <= scan_idx_next;
    dat_idx   <= dat_idx_next;
    dat_lane  <= dat_lane_next;
    iss_lane  <= iss_lane_next;
    start_pos <= start_pos_next;
    end_pos   <= end_pos_next;
    acc       <= acc_next;
  end

  always_comb begin
    state_next     = state;
    wr_line_next   = wr_line;
    rd_line_next   = rd_line;
    wr_pos_next    = wr_pos;
    zero_addr_next = zero_addr;
    scan_idx_next  = scan_idx;
    dat_vld_next   = 1'b0;
    dat_idx_next   = dat_idx;
    dat_lane_next  = dat_lane;
    iss_lane_next  = iss_lane;
    start_pos_next = start_pos;
    end_pos_next   = end_pos;
    acc_next       = acc;
    mem_we         = 1'b0;
    mem_waddr      = entry_addr(wr_line, wr_pos);
    mem_wdata      = req.rx_byte;
    mem_raddr      = entry_addr(rd_line, scan_idx[POS_W-1:0]);
    out_load       = 1'b0;

    unique case (state)
      nlrb_pkg::ST_IDLE: begin
        if (req_take && req.action == nlrb_pkg::ACT_RECEIVE) begin
          mem_we = 1'b1;
          if (req.rx_byte == nlrb_pkg::NEWLINE_CHAR) begin
            // commit the line; terminator goes in the next slot if it fits
            wr_line_next = line_inc(wr_line);
            wr_pos_next  = '0;
            if (pos_inc < IDX_W'(LINE_BYTES)) begin
              zero_addr_next = entry_addr(wr_line, pos_inc[POS_W-1:0]);
              state_next     = nlrb_pkg::ST_ZERO;
            end
          end else if (pos_inc == IDX_W'(LINE_BYTES)) begin
            // full line restarts without commit
            wr_pos_next = '0;
          end else begin
            wr_pos_next = pos_inc[POS_W-1:0];
          end
        end else if (req_take) begin
          acc_next            = '0;
          if (rd_line == wr_line) begin
            acc_next.status = nlrb_pkg::STATUS_EMPTY;
            state_next      = nlrb_pkg::ST_SEND;
          end else begin
            acc_next.status = nlrb_pkg::STATUS_CHUNK;
            scan_idx_next   = '0;
            start_pos_next  = '0;
            state_next      = nlrb_pkg::ST_SCAN;
          end
        end
      end

      nlrb_pkg::ST_ZERO: begin
        mem_we     = 1'b1;
        mem_waddr  = zero_addr;
        mem_wdata  = '0;
        state_next = nlrb_pkg::ST_IDLE;
      end

      nlrb_pkg::ST_SCAN: begin
        // one read issued per cycle, its data checked in the following cycle
        if (scan_idx < IDX_W'(LINE_BYTES)) begin
          scan_idx_next = scan_idx + 1'b1;
          dat_vld_next  = 1'b1;
          dat_idx_next  = scan_idx[POS_W-1:0];
        end
        if (dat_vld) begin
          if (mem_rdata == nlrb_pkg::DOLLAR_CHAR) begin
            start_pos_next = dat_idx;
          end
          if (mem_rdata == nlrb_pkg::NEWLINE_CHAR) begin
            end_pos_next  = dat_idx;
            scan_idx_next = {1'b0, start_pos};
            dat_vld_next  = 1'b0;
            iss_lane_next = '0;
            state_next    = nlrb_pkg::ST_GATHER;
          end else if (dat_idx == POS_W'(LINE_BYTES - 1)) begin
            // no newline in the line: nothing to send, drop it
            rd_line_next = line_inc(rd_line);
            dat_vld_next = 1'b0;
            state_next   = nlrb_pkg::ST_IDLE;
          end
        end
      end

      nlrb_pkg::ST_GATHER: begin
        if (iss_lane < 3'(nlrb_pkg::CHUNK_BYTES) && scan_idx <= {1'b0, end_pos}) begin
          scan_idx_next = scan_idx + 1'b1;
          iss_lane_next = iss_lane + 1'b1;
          dat_vld_next  = 1'b1;
          dat_idx_next  = scan_idx[POS_W-1:0];
          dat_lane_next = iss_lane[1:0];
        end
        if (dat_vld) begin
          acc_next.chunk[8*dat_lane +: 8] = mem_rdata;
          acc_next.byte_count             = 3'(dat_lane) + 3'd1;
          if (dat_idx == end_pos) begin
            acc_next.last = 1'b1;
            state_next    = nlrb_pkg::ST_SEND;
          end else if (dat_lane == 2'(nlrb_pkg::CHUNK_BYTES - 1)) begin
            state_next = nlrb_pkg::ST_SEND;
          end
        end
      end

      nlrb_pkg::ST_SEND: begin
        if (out_free) begin
          out_load = 1'b1;
          if (acc.status == nlrb_pkg::STATUS_EMPTY) begin
            state_next = nlrb_pkg::ST_IDLE;
          end else if (acc.last) begin
            rd_line_next = line_inc(rd_line);
            state_next   = nlrb_pkg::ST_IDLE;
          end else begin
            acc_next.chunk      = '0;
            acc_next.byte_count = '0;
            iss_lane_next       = '0;
            state_next          = nlrb_pkg::ST_GATHER;
          end
        end
      end

      default: begin
        state_next = nlrb_pkg::ST_IDLE;
      end
    endcase
  end

  nlrb_mem #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  nlrb_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .load_word(acc),
    .free     (out_free),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

// ===== tb/nlrb_sentence_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nlrb_sentence_checker
// watches both channels of the line ring buffer, keeps its own copy of the
// ring and compares every response word with the predicted sentence chunks
// ----------------------------------------------------------------------------
module nlrb_sentence_checker #(
  parameter int LINE_BYTES = 128,
  parameter int LINE_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_stall,
  input  nlrb_pkg::req_word_t req,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  input  nlrb_pkg::rsp_word_t rsp,
  output int                  fail_count,
  output int                  pending
);

  logic [7:0]          line_mem [LINE_COUNT][LINE_BYTES];
  int unsigned         wr_line;
  int unsigned         rd_line;
  int unsigned         wr_pos;
  nlrb_pkg::rsp_word_t sentence_q [$];
  nlrb_pkg::rsp_word_t want;
  int                  fails;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (fails < 30) begin
      $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
    end
    fails++;
  endtask

  task automatic store_byte(logic [7:0] b);
    line_mem[wr_line][wr_pos] = b;
    wr_pos++;
    if (b == nlrb_pkg::NEWLINE_CHAR) begin
      // terminator only when it still fits in the line
      if (wr_pos < LINE_BYTES) begin
        line_mem[wr_line][wr_pos] = 8'h00;
      end
      wr_pos  = 0;
      wr_line = (wr_line + 1) % LINE_COUNT;
    end
    if (wr_pos >= LINE_BYTES) begin
      wr_pos = 0;
    end
  endtask

  task automatic drain_line();
    int                  head;
    int                  tail;
    int                  i;
    int                  k;
    int                  cnt;
    logic                found;
    nlrb_pkg::rsp_word_t w;
    if (rd_line == wr_line) begin
      w        = '0;
      w.status = nlrb_pkg::STATUS_EMPTY;
      sentence_q.push_back(w);
      return;
    end
    head  = 0;
    tail  = 0;
    found = 1'b0;
    for (i = 0; i < LINE_BYTES && !found; i++) begin
      if (line_mem[rd_line][i] == nlrb_pkg::DOLLAR_CHAR) begin
        head = i;
      end else if (line_mem[rd_line][i] == nlrb_pkg::NEWLINE_CHAR) begin
        tail  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      for (i = head; i <= tail; i += nlrb_pkg::CHUNK_BYTES) begin
        w        = '0;
        w.status = nlrb_pkg::STATUS_CHUNK;
        cnt      = 0;
        for (k = 0; k < nlrb_pkg::CHUNK_BYTES && i + k <= tail; k++) begin
          w.chunk[8*k +: 8] = line_mem[rd_line][i+k];
          cnt++;
        end
        w.byte_count = cnt[2:0];
        w.last       = (i + nlrb_pkg::CHUNK_BYTES > tail);
        sentence_q.push_back(w);
      end
    end
    rd_line = (rd_line + 1) % LINE_COUNT;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wr_line = 0;
      rd_line = 0;
      wr_pos  = 0;
      sentence_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (sentence_q.size() == 0) begin
          report_mismatch("word with nothing expected, chunk", rsp.chunk, '0);
        end else begin
          want = sentence_q.pop_front();
          if (rsp.status !== want.status) begin
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          end
          if (rsp.chunk !== want.chunk) begin
            report_mismatch("chunk", rsp.chunk, want.chunk);
          end
          if (rsp.byte_count !== want.byte_count) begin
            report_mismatch("byte_count", 32'(rsp.byte_count), 32'(want.byte_count));
          end
          if (rsp.last !== want.last) begin
            report_mismatch("last", 32'(rsp.last), 32'(want.last));
          end
        end
      end
      if (req_valid && !req_stall) begin
        if (req.action == nlrb_pkg::ACT_READ) begin
          drain_line();
        end else begin
          store_byte(req.rx_byte);
        end
      end
    end
    fail_count <= fails;
    pending    <= sentence_q.size();
  end

endmodule

// ===== tb/tb_nmea_line_ring_buffer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nmea_line_ring_buffer
// stimulus and verdict for the nmea line ring buffer: a directed opening,
// two full-length lines sent with no idling, a ring overrun, then a short
// random mix of sentences, noise and reads, with random idling on both sides,
// one long response hold-off and one drain pause. the checker beside the
// block does all prediction
// ----------------------------------------------------------------------------
module tb_nmea_line_ring_buffer;

  localparam int LINE_BYTES    = 128;
  localparam int LINE_COUNT    = 8;
  localparam int RANDOM_ITEMS  = 20;
  // long enough for a read to block the request side for a good while
  localparam int HOLD_CYCLES   = 400;
  // room for a full 32-chunk read to finish
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [7:0] CR_CHAR = 8'h0D;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  nlrb_pkg::req_word_t req;
  logic                rsp_valid;
  logic                rsp_stall;
  nlrb_pkg::rsp_word_t rsp;

  int        fail_count;
  int        pending;

  // calm: no idling on either side; hold_off_req: ask for one long stall
  logic      calm;
  logic      hold_off_req;

  int        words_sent;
  int        reads_sent;
  int        lines_sent;
  int        cycle_count;

  nmea_line_ring_buffer #(
    .LINE_BYTES(LINE_BYTES),
    .LINE_COUNT(LINE_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  nlrb_sentence_checker #(
    .LINE_BYTES(LINE_BYTES),
    .LINE_COUNT(LINE_COUNT)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle budget, far above the slowest legal run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_nmea_line_ring_buffer NOT OK");
    $finish;
  end

  // response side: random stall, or one long hold-off when asked
  initial begin : rsp_stall_gen
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_off_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      rsp_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 35);
    end
  end

  // any byte except a newline; optionally no dollar sign either
  function automatic logic [7:0] text_byte(logic no_dollar);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == nlrb_pkg::NEWLINE_CHAR || (no_dollar && b == nlrb_pkg::DOLLAR_CHAR));
    return b;
  endfunction

  // offer one word after a random gap and hold it until it is taken
  task automatic send_word(logic act, logic [7:0] b);
    nlrb_pkg::req_word_t w;
    w.action  = act;
    w.rx_byte = b;
    if (!calm) begin
      while ($urandom_range(99) < 35) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
    words_sent++;
    if (act == nlrb_pkg::ACT_READ) begin
      reads_sent++;
    end
  endtask

  // well-formed sentence: '$', printable body, cr, newline
  task automatic send_sentence(int body);
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::DOLLAR_CHAR);
    for (int i = 0; i < body; i++) begin
      send_word(nlrb_pkg::ACT_RECEIVE, 8'($urandom_range(32, 126)));
    end
    send_word(nlrb_pkg::ACT_RECEIVE, CR_CHAR);
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::NEWLINE_CHAR);
    lines_sent++;
  endtask

  // garbage line, possibly with stray dollar signs, possibly empty
  task automatic send_noise(int len);
    for (int i = 0; i < len; i++) begin
      send_word(nlrb_pkg::ACT_RECEIVE, text_byte(1'b0));
    end
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::NEWLINE_CHAR);
    lines_sent++;
  endtask

  initial begin : stimulus
    int   r;
    int   read_pct;
    int   well_pct;
    int   junk_pct;
    int   stop_at;
    logic held;
    logic paused;

    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    words_sent   = 0;
    reads_sent   = 0;
    lines_sent   = 0;
    held         = 1'b0;
    paused       = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // read of the empty ring right after reset
    send_word(nlrb_pkg::ACT_READ, 8'h00);

    // byte extremes, sentence starts at the dollar in the middle
    send_word(nlrb_pkg::ACT_RECEIVE, 8'hFF);
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::DOLLAR_CHAR);
    send_word(nlrb_pkg::ACT_RECEIVE, 8'h00);
    send_word(nlrb_pkg::ACT_RECEIVE, 8'h41);
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::NEWLINE_CHAR);

    // two dollars: output from the later one
    send_word(nlrb_pkg::ACT_RECEIVE, 8'h78);
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::DOLLAR_CHAR);
    send_word(nlrb_pkg::ACT_RECEIVE, 8'h61);
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::DOLLAR_CHAR);
    send_word(nlrb_pkg::ACT_RECEIVE, 8'h62);
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::NEWLINE_CHAR);

    // no dollar: output from position 0
    send_word(nlrb_pkg::ACT_RECEIVE, 8'h71);
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::NEWLINE_CHAR);

    // bare newline
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::NEWLINE_CHAR);
    lines_sent += 4;

    // drain the four lines, then one more read on the empty ring
    send_word(nlrb_pkg::ACT_READ, 8'hFF);
    send_word(nlrb_pkg::ACT_READ, 8'h5A);
    send_word(nlrb_pkg::ACT_READ, 8'hA5);
    send_word(nlrb_pkg::ACT_READ, 8'h00);
    send_word(nlrb_pkg::ACT_READ, 8'hFF);

    // long stretch with no idling on either side
    calm <= 1'b1;

    // newline in the last slot: whole line comes back as 32 chunks and
    // the terminator after it is dropped
    for (int i = 0; i < LINE_BYTES - 1; i++) begin
      send_word(nlrb_pkg::ACT_RECEIVE, text_byte(1'b1));
    end
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::NEWLINE_CHAR);
    lines_sent++;
    send_word(nlrb_pkg::ACT_READ, 8'h00);

    // a full line without newline wraps the position back to 0; the
    // sentence written after the wrap is what the read sees
    for (int i = 0; i < LINE_BYTES; i++) begin
      send_word(nlrb_pkg::ACT_RECEIVE, text_byte(1'b0));
    end
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::DOLLAR_CHAR);
    send_word(nlrb_pkg::ACT_RECEIVE, 8'h47);
    send_word(nlrb_pkg::ACT_RECEIVE, 8'h50);
    send_word(nlrb_pkg::ACT_RECEIVE, CR_CHAR);
    send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::NEWLINE_CHAR);
    lines_sent++;
    send_word(nlrb_pkg::ACT_READ, 8'h00);

    calm <= 1'b0;

    // ring overrun: one more bare line than the ring holds, no read in
    // between; the write line laps the read line, only the newest line is
    // left and the read after it finds the ring empty
    repeat (LINE_COUNT + 1) send_word(nlrb_pkg::ACT_RECEIVE, nlrb_pkg::NEWLINE_CHAR);
    lines_sent += LINE_COUNT + 1;
    send_word(nlrb_pkg::ACT_READ, 8'h00);
    send_word(nlrb_pkg::ACT_READ, 8'h00);

    // short random mix
    stop_at = words_sent + RANDOM_ITEMS;
    while (words_sent < stop_at) begin
      // long response hold-off while requests keep coming; of two reads
      // back to back the second cannot hand over its word, so the block
      // stalls its request side
      if (!held) begin
        held = 1'b1;
        hold_off_req <= 1'b1;
        send_word(nlrb_pkg::ACT_READ, 8'($urandom_range(255)));
        send_word(nlrb_pkg::ACT_READ, 8'($urandom_range(255)));
        continue;
      end

      // stop sending until every expected word has arrived
      if (!paused && words_sent >= stop_at - 16) begin
        paused = 1'b1;
        req_valid <= 1'b0;
        do begin
          @(posedge clk);
        end while (pending != 0);
        continue;
      end

      read_pct = (words_sent < stop_at - 10) ? 20 : 50;
      well_pct = read_pct + (100 - read_pct) * 3 / 4;
      junk_pct = well_pct + (100 - read_pct) / 10;
      r = $urandom_range(99);
      if (r < read_pct) begin
        send_word(nlrb_pkg::ACT_READ, 8'($urandom_range(255)));
      end else if (r < well_pct) begin
        send_sentence($urandom_range(0, 10));
      end else if (r < junk_pct) begin
        // leftover bytes in front of a sentence
        repeat ($urandom_range(1, 3)) send_word(nlrb_pkg::ACT_RECEIVE, text_byte(1'b0));
        send_sentence($urandom_range(0, 10));
      end else begin
        send_noise($urandom_range(0, 8));
      end
    end
    req_valid <= 1'b0;

    do begin
      @(posedge clk);
    end while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d request words: %0d reads and %0d terminated lines,",
             words_sent, reads_sent, lines_sent);
    $display("including ring overrun, full-line wrap and a 32-chunk sentence");
    if (fail_count == 0) begin
      $display("tb_nmea_line_ring_buffer OK");
    end else begin
      $display("tb_nmea_line_ring_buffer NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/nlrb_pkg.sv
design/nlrb_mem.sv
design/nlrb_out_reg.sv
design/nmea_line_ring_buffer.sv
tb/nlrb_sentence_checker.sv
tb/tb_nmea_line_ring_buffer.sv
